FILE: design/bts_pkg.sv
// package: shared types, constants and blend functions for the bilinear texture sampler
`default_nettype none

package bts_pkg;

   localparam int CFG_DIM_W   = 9;
   localparam int CFG_CHAN_W  = 3;
   localparam int CFG_DIM_MAX = (1 << CFG_DIM_W) - 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = CFG_DIM_W;

   localparam int INDEX_W     = 16;
   localparam int TEXEL_W     = 32;
   localparam int COORD_W     = 32;
   localparam int FRAC_W      = 16;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 4;
   localparam int RESULT_W    = 16;
   localparam int PX_W        = FRAC_W + CFG_DIM_W;
   localparam int ADDR_W      = 2 * CFG_DIM_W;
   localparam int HBLEND_W    = CHAN_W + FRAC_W;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [RESULT_W-1:0] FULL_WHITE   = 16'hFF00;
   localparam logic [CHAN_W-1:0]   ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH    = 2'd0,
      CSR_HEIGHT   = 2'd1,
      CSR_CHANNELS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0]  width;
      logic [CFG_DIM_W-1:0]  height;
      logic [CFG_CHAN_W-1:0] chans;
   } cfg_type;

   typedef struct packed {
      logic                sample;
      logic                white;
      logic                wr_ok;
      logic [ADDR_W-1:0]   addr00;
      logic [ADDR_W-1:0]   addr01;
      logic [ADDR_W-1:0]   addr10;
      logic [ADDR_W-1:0]   addr11;
      logic [TEXEL_W-1:0]  data;
      logic [FRAC_W-1:0]   tx;
      logic [FRAC_W-1:0]   ty;
   } queue_entry_type;

   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_set_type;

   function automatic chan_set_type expand_texel(input logic [TEXEL_W-1:0] word,
                                                 input logic [CFG_CHAN_W-1:0] chans);
      chan_set_type c;
      c[0] = word[7:0];
      c[1] = (chans > 3'd1) ? word[15:8]  : word[7:0];
      c[2] = (chans > 3'd2) ? word[23:16] : word[7:0];
      c[3] = (chans > 3'd3) ? word[31:24] : ALPHA_OPAQUE;
      return c;
   endfunction

   // a*2^16 + (b-a)*t, always within 0..255*2^16
   function automatic logic [HBLEND_W-1:0] horiz_blend(input logic [CHAN_W-1:0] a,
                                                       input logic [CHAN_W-1:0] b,
                                                       input logic [FRAC_W-1:0] t);
      logic signed [HBLEND_W+1:0] diff;
      logic signed [HBLEND_W+1:0] prod;
      logic signed [HBLEND_W+1:0] sum;
      diff = (HBLEND_W+2)'($signed({1'b0, b})) - (HBLEND_W+2)'($signed({1'b0, a}));
      prod = diff * (HBLEND_W+2)'($signed({1'b0, t}));
      sum  = $signed({2'b00, a, {FRAC_W{1'b0}}}) + prod;
      return sum[HBLEND_W-1:0];
   endfunction

   // top*2^16 + (bot-top)*t, then keep bits 39:24
   function automatic logic [RESULT_W-1:0] vert_blend(input logic [HBLEND_W-1:0] top,
                                                      input logic [HBLEND_W-1:0] bot,
                                                      input logic [FRAC_W-1:0] t);
      logic signed [HBLEND_W+FRAC_W+1:0] diff;
      logic signed [HBLEND_W+FRAC_W+1:0] prod;
      logic signed [HBLEND_W+FRAC_W+1:0] sum;
      diff = (HBLEND_W+FRAC_W+2)'($signed({1'b0, bot}))
           - (HBLEND_W+FRAC_W+2)'($signed({1'b0, top}));
      prod = diff * (HBLEND_W+FRAC_W+2)'($signed({1'b0, t}));
      sum  = $signed({2'b00, top, {FRAC_W{1'b0}}}) + prod;
      return sum[HBLEND_W+FRAC_W-1:HBLEND_W];
   endfunction

endpackage

`default_nettype wire

FILE: design/bts_if.sv
// interfaces: request and response channels of the bilinear texture sampler
`default_nettype none

interface bts_req_if;
   import bts_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [INDEX_W-1:0]         texel_index;
   logic [TEXEL_W-1:0]         texel_data;
   logic signed [COORD_W-1:0]  u_coord;
   logic signed [COORD_W-1:0]  v_coord;

   modport source (output valid, mode, texel_index, texel_data, u_coord, v_coord,
                   input ready);
   modport sink   (input valid, mode, texel_index, texel_data, u_coord, v_coord,
                   output ready);
endinterface

interface bts_rsp_if;
   import bts_pkg::*;
   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] red;
   logic [RESULT_W-1:0] green;
   logic [RESULT_W-1:0] blue;
   logic [RESULT_W-1:0] alpha;

   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

`default_nettype wire

FILE: design/bilinear_texture_sampler_unit.sv
// top level: bilinear texture sampler with wrap-around addressing
//
// channel   dir   beat                                                   handshake
// req       in    mode, texel_index, texel_data, u_coord, v_coord        valid / ready
// rsp       out   red, green, blue, alpha                                valid / ready
// csr       in    csr_index, csr_data                                    csr_wr_en
//
// one beat per cycle in and out unless stalled; rsp.valid is registered in b3_v_ff
// two coordinate stages, a 4-entry queue, store read, horizontal and vertical blend
// four texel reads per cycle from two store copies with two read ports each
// reset initialises control and CSRs; data registers and texel store are not cleared
// rsp stalls fill the queue before req.ready drops
`default_nettype none

module bilinear_texture_sampler_unit
   import bts_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bts_req_if.sink                     req_bus,
   bts_rsp_if.source                   rsp_bus,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic [CFG_DIM_W-1:0]  width_ff;
   logic [CFG_DIM_W-1:0]  height_ff;
   logic [CFG_CHAN_W-1:0] chans_ff;
   cfg_type               cfg;

   logic                  push_valid;
   queue_entry_type       push_entry;
   logic                  queue_full;
   logic                  pop;
   logic                  pop_valid;
   queue_entry_type       pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_DIM_W'(1);
         height_ff <= CFG_DIM_W'(1);
         chans_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDTH:    width_ff  <= csr_data[CFG_DIM_W-1:0];
            CSR_HEIGHT:   height_ff <= csr_data[CFG_DIM_W-1:0];
            CSR_CHANNELS: chans_ff  <= csr_data[CFG_CHAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.chans  = chans_ff;

   bts_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   bts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   bts_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire

FILE: design/bts_front.sv
// front end: accepts beats, scales coordinates and forms the four texel addresses
`default_nettype none

module bts_front
   import bts_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cfg_type         cfg,
   bts_req_if.sink              req,
   output logic                 push_valid,
   output queue_entry_type      push_entry,
   input  wire logic            queue_full
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int WCAP  = (MAX_WIDTH  < CFG_DIM_MAX) ? MAX_WIDTH  : CFG_DIM_MAX;
   localparam int HCAP  = (MAX_HEIGHT < CFG_DIM_MAX) ? MAX_HEIGHT : CFG_DIM_MAX;

   logic [CFG_DIM_W-1:0] w_eff;
   logic [CFG_DIM_W-1:0] h_eff;
   logic [CFG_DIM_W-1:0] wm1;
   logic [CFG_DIM_W-1:0] hm1;
   logic                 white;
   logic                 f1_ready;
   logic                 f2_ready;

   logic                 f1_v_ff;
   logic                 f1_sample_ff;
   logic                 f1_white_ff;
   logic                 f1_wr_ok_ff;
   logic [INDEX_W-1:0]   f1_index_ff;
   logic [TEXEL_W-1:0]   f1_data_ff;
   logic [PX_W-1:0]      f1_px_ff;
   logic [PX_W-1:0]      f1_py_ff;

   logic [CFG_DIM_W-1:0] x0;
   logic [CFG_DIM_W-1:0] y0;
   logic [CFG_DIM_W:0]   x0_inc;
   logic [CFG_DIM_W:0]   y0_inc;
   logic [CFG_DIM_W-1:0] x1;
   logic [CFG_DIM_W-1:0] y1;

   logic                 f2_v_ff;
   logic                 f2_sample_ff;
   logic                 f2_white_ff;
   logic                 f2_wr_ok_ff;
   logic [INDEX_W-1:0]   f2_index_ff;
   logic [TEXEL_W-1:0]   f2_data_ff;
   logic [CFG_DIM_W-1:0] f2_x0_ff;
   logic [CFG_DIM_W-1:0] f2_x1_ff;
   logic [ADDR_W-1:0]    f2_base0_ff;
   logic [ADDR_W-1:0]    f2_base1_ff;
   logic [FRAC_W-1:0]    f2_tx_ff;
   logic [FRAC_W-1:0]    f2_ty_ff;

   assign w_eff = (32'(cfg.width)  > 32'(WCAP)) ? CFG_DIM_W'(WCAP) : cfg.width;
   assign h_eff = (32'(cfg.height) > 32'(HCAP)) ? CFG_DIM_W'(HCAP) : cfg.height;
   assign wm1   = w_eff - CFG_DIM_W'(1);
   assign hm1   = h_eff - CFG_DIM_W'(1);
   assign white = (cfg.chans == '0) || (w_eff == '0) || (h_eff == '0);

   assign f2_ready  = !f2_v_ff || !queue_full;
   assign f1_ready  = !f1_v_ff || f2_ready;
   assign req.ready = f1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         if (f1_ready) f1_v_ff <= req.valid;
         if (f2_ready) f2_v_ff <= f1_v_ff;
      end
   end

   // stage 1: fractional coordinate times (size - 1)
   always_ff @(posedge clock) begin
      if (f1_ready) begin
         f1_sample_ff <= req.mode;
         f1_white_ff  <= white;
         f1_wr_ok_ff  <= 32'(req.texel_index) < 32'(DEPTH);
         f1_index_ff  <= req.texel_index;
         f1_data_ff   <= req.texel_data;
         f1_px_ff     <= PX_W'(req.u_coord[FRAC_W-1:0]) * PX_W'(wm1);
         f1_py_ff     <= PX_W'(req.v_coord[FRAC_W-1:0]) * PX_W'(hm1);
      end
   end

   always_comb begin
      x0     = f1_px_ff[PX_W-1:FRAC_W];
      y0     = f1_py_ff[PX_W-1:FRAC_W];
      x0_inc = {1'b0, x0} + (CFG_DIM_W+1)'(1);
      y0_inc = {1'b0, y0} + (CFG_DIM_W+1)'(1);
      x1     = (x0_inc == {1'b0, w_eff}) ? '0 : x0_inc[CFG_DIM_W-1:0];
      y1     = (y0_inc == {1'b0, h_eff}) ? '0 : y0_inc[CFG_DIM_W-1:0];
   end

   // stage 2: row base addresses
   always_ff @(posedge clock) begin
      if (f2_ready) begin
         f2_sample_ff <= f1_sample_ff;
         f2_white_ff  <= f1_white_ff;
         f2_wr_ok_ff  <= f1_wr_ok_ff;
         f2_index_ff  <= f1_index_ff;
         f2_data_ff   <= f1_data_ff;
         f2_x0_ff     <= x0;
         f2_x1_ff     <= x1;
         f2_base0_ff  <= ADDR_W'(y0) * ADDR_W'(w_eff);
         f2_base1_ff  <= ADDR_W'(y1) * ADDR_W'(w_eff);
         f2_tx_ff     <= f1_px_ff[FRAC_W-1:0];
         f2_ty_ff     <= f1_py_ff[FRAC_W-1:0];
      end
   end

   always_comb begin
      push_valid        = f2_v_ff && !queue_full;
      push_entry.sample = f2_sample_ff;
      push_entry.white  = f2_white_ff;
      push_entry.wr_ok  = f2_wr_ok_ff;
      push_entry.addr00 = f2_sample_ff ? (f2_base0_ff + ADDR_W'(f2_x0_ff))
                                       : ADDR_W'(f2_index_ff);
      push_entry.addr01 = f2_base0_ff + ADDR_W'(f2_x1_ff);
      push_entry.addr10 = f2_base1_ff + ADDR_W'(f2_x0_ff);
      push_entry.addr11 = f2_base1_ff + ADDR_W'(f2_x1_ff);
      push_entry.data   = f2_data_ff;
      push_entry.tx     = f2_tx_ff;
      push_entry.ty     = f2_ty_ff;
   end

endmodule

`default_nettype wire

FILE: design/bts_queue.sv
// queue: short fifo between front end and back end
`default_nettype none

module bts_queue
   import bts_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire queue_entry_type push_entry,
   output logic                 full,
   input  wire logic            pop,
   output logic                 pop_valid,
   output queue_entry_type      pop_entry
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type  entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

FILE: design/bts_back.sv
// back end: texel store, four-texel fetch and two-pass bilinear blend
`default_nettype none

module bts_back
   import bts_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cfg_type         cfg,
   input  wire logic            pop_valid,
   input  wire queue_entry_type pop_entry,
   output logic                 pop,
   bts_rsp_if.source            rsp
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // two copies, each with two read ports: the top copy reads row y0, the bottom copy row y1
   logic [TEXEL_W-1:0]  top_store_ff [DEPTH];
   logic [TEXEL_W-1:0]  bot_store_ff [DEPTH];

   logic                out_ready;
   logic                b2_ready;
   logic                b1_ready;
   logic                store_wr;
   logic                b1_load;

   logic                b1_v_ff;
   logic                b1_white_ff;
   logic [TEXEL_W-1:0]  b1_t0_ff;
   logic [TEXEL_W-1:0]  b1_t1_ff;
   logic [TEXEL_W-1:0]  b1_b0_ff;
   logic [TEXEL_W-1:0]  b1_b1_ff;
   logic [FRAC_W-1:0]   b1_tx_ff;
   logic [FRAC_W-1:0]   b1_ty_ff;

   chan_set_type        c00;
   chan_set_type        c01;
   chan_set_type        c10;
   chan_set_type        c11;
   logic [HBLEND_W-1:0] h_top [NUM_CHAN];
   logic [HBLEND_W-1:0] h_bot [NUM_CHAN];

   logic                b2_v_ff;
   logic                b2_white_ff;
   logic [HBLEND_W-1:0] b2_top_ff [NUM_CHAN];
   logic [HBLEND_W-1:0] b2_bot_ff [NUM_CHAN];
   logic [FRAC_W-1:0]   b2_ty_ff;

   logic [RESULT_W-1:0] v_mix [NUM_CHAN];

   logic                b3_v_ff;
   logic [RESULT_W-1:0] red_ff;
   logic [RESULT_W-1:0] green_ff;
   logic [RESULT_W-1:0] blue_ff;
   logic [RESULT_W-1:0] alpha_ff;

   assign out_ready = !b3_v_ff || rsp.ready;
   assign b2_ready  = !b2_v_ff || out_ready;
   assign b1_ready  = !b1_v_ff || b2_ready;

   assign pop      = pop_valid && (!pop_entry.sample || b1_ready);
   assign store_wr = pop && !pop_entry.sample && pop_entry.wr_ok;
   assign b1_load  = pop && pop_entry.sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         b3_v_ff <= 1'b0;
      end else begin
         if (b1_ready)  b1_v_ff <= b1_load;
         if (b2_ready)  b2_v_ff <= b1_v_ff;
         if (out_ready) b3_v_ff <= b2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         top_store_ff[AW'(pop_entry.addr00)] <= pop_entry.data;
         bot_store_ff[AW'(pop_entry.addr00)] <= pop_entry.data;
      end
   end

   always_ff @(posedge clock) begin
      if (b1_load) begin
         b1_t0_ff    <= top_store_ff[AW'(pop_entry.addr00)];
         b1_t1_ff    <= top_store_ff[AW'(pop_entry.addr01)];
         b1_b0_ff    <= bot_store_ff[AW'(pop_entry.addr10)];
         b1_b1_ff    <= bot_store_ff[AW'(pop_entry.addr11)];
         b1_white_ff <= pop_entry.white;
         b1_tx_ff    <= pop_entry.tx;
         b1_ty_ff    <= pop_entry.ty;
      end
   end

   // horizontal pass
   always_comb begin
      c00 = expand_texel(b1_t0_ff, cfg.chans);
      c01 = expand_texel(b1_t1_ff, cfg.chans);
      c10 = expand_texel(b1_b0_ff, cfg.chans);
      c11 = expand_texel(b1_b1_ff, cfg.chans);
      for (int k = 0; k < NUM_CHAN; k++) begin
         h_top[k] = horiz_blend(c00[k], c01[k], b1_tx_ff);
         h_bot[k] = horiz_blend(c10[k], c11[k], b1_tx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (b2_ready) begin
         b2_white_ff <= b1_white_ff;
         b2_ty_ff    <= b1_ty_ff;
         for (int k = 0; k < NUM_CHAN; k++) begin
            b2_top_ff[k] <= h_top[k];
            b2_bot_ff[k] <= h_bot[k];
         end
      end
   end

   // vertical pass
   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         v_mix[k] = vert_blend(b2_top_ff[k], b2_bot_ff[k], b2_ty_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         red_ff   <= b2_white_ff ? FULL_WHITE : v_mix[0];
         green_ff <= b2_white_ff ? FULL_WHITE : v_mix[1];
         blue_ff  <= b2_white_ff ? FULL_WHITE : v_mix[2];
         alpha_ff <= b2_white_ff ? FULL_WHITE : v_mix[3];
      end
   end

   assign rsp.valid = b3_v_ff;
   assign rsp.red   = red_ff;
   assign rsp.green = green_ff;
   assign rsp.blue  = blue_ff;
   assign rsp.alpha = alpha_ff;

endmodule

`default_nettype wire
